// File: rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// shared widths, codes and cell control types for the sorted list engine
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // what a cell loads at the next apply edge
   typedef enum logic [1:0] {
      ACT_HOLD       = 2'd0,
      ACT_LOAD_KEY   = 2'd1,
      ACT_TAKE_LEFT  = 2'd2,
      ACT_TAKE_RIGHT = 2'd3
   } cell_act_type;

   typedef struct packed {
      cell_act_type               act;
      logic signed [VALUE_W-1:0]  key;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// one slot of the sorted list: holds a value, compares it against the key
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell #(
   parameter int DEPTH = sle_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  wire logic                               clock,
   input  wire sle_pkg::cell_ctrl_type             ctrl,
   input  wire logic [$clog2(DEPTH+1)-1:0]         count,
   input  wire logic signed [sle_pkg::VALUE_W-1:0] left_value,
   input  wire logic signed [sle_pkg::VALUE_W-1:0] right_value,
   output logic signed [sle_pkg::VALUE_W-1:0]      cell_value,
   output logic                                    lt_flag,
   output logic                                    eq_flag
);

   localparam int CNT_W = $clog2(DEPTH+1);

   logic signed [sle_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                               lt_ff, lt_in;
   logic                               eq_ff, eq_in;
   logic                               occupied;

   // slot is live when it lies below the fill count
   assign occupied = CNT_W'(INDEX) < count;

   always_comb begin
      lt_in = occupied && (value_ff < ctrl.key);
      eq_in = occupied && (value_ff == ctrl.key);
      case (ctrl.act)
         sle_pkg::ACT_LOAD_KEY:   value_in = ctrl.key;
         sle_pkg::ACT_TAKE_LEFT:  value_in = left_value;
         sle_pkg::ACT_TAKE_RIGHT: value_in = right_value;
         default:                 value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign cell_value = value_ff;
   assign lt_flag    = lt_ff;
   assign eq_flag    = eq_ff;

endmodule

`default_nettype wire

// File: rtl/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// ascending list of signed keys with insert, delete-first-equal and search
// ----------------------------------------------------------------------------
//
//   channel   transfer when          payload
//   -------   --------------------   ------------------------------------------
//   request   start & !busy          req_op, req_value
//   response  rsp_strobe (1 cycle)   rsp_status, rsp_position, rsp_entry_count
//
// after the request transfer come a compare cycle, in which every cell checks
// its value against the key and registers less-than / equal flags, and an
// apply cycle, in which every cell shifts, loads the key or holds
// busy is high during compare and apply; the response shows in the next
// cycle, with busy low, so the next command transfers at the edge that ends
// it; no new command is taken while one is in compare or apply
// the receiver cannot stall, the response is valid for exactly one cycle
// reset clears the fill count and the sequencer; the cells need no clear,
// a slot at or above the fill count is never looked at
//
`default_nettype none

module sorted_list_engine #(
   parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [sle_pkg::OP_W-1:0]            req_op,
   input  wire logic signed [sle_pkg::VALUE_W-1:0]  req_value,
   output logic                                     rsp_strobe,
   output logic [sle_pkg::STATUS_W-1:0]             rsp_status,
   output logic [sle_pkg::POS_W-1:0]                rsp_position,
   output logic [sle_pkg::COUNT_W-1:0]              rsp_entry_count
);

   localparam int CNT_W = $clog2(DEPTH+1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CMP   = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // captured command
   logic [sle_pkg::OP_W-1:0]           op_ff, op_in;
   logic signed [sle_pkg::VALUE_W-1:0] key_ff, key_in;

   logic [CNT_W-1:0]                   count_ff, count_in;

   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic [sle_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [sle_pkg::POS_W-1:0]          rsp_position_ff, rsp_position_in;
   logic [sle_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   // chain of cells
   sle_pkg::cell_ctrl_type             ctrl [DEPTH];
   logic signed [sle_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]                   lt_vec;
   logic [DEPTH-1:0]                   eq_vec;

   logic                               accept;
   logic                               is_insert, is_delete, is_search;
   logic                               table_full;
   logic                               key_found;
   logic [DEPTH-1:0]                   boundary;
   logic [sle_pkg::POS_W-1:0]          boundary_pos;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign is_insert  = (op_ff == sle_pkg::OP_INSERT);
   assign is_delete  = (op_ff == sle_pkg::OP_DELETE);
   assign is_search  = (op_ff == sle_pkg::OP_SEARCH);
   assign table_full = (count_ff == CNT_W'(DEPTH));
   assign key_found  = |eq_vec;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [sle_pkg::VALUE_W-1:0] left_nb, right_nb;

         // the outermost cells see themselves at the open ends
         if (g == 0) begin : g_first
            assign left_nb = cell_value[g];
         end else begin : g_inner_l
            assign left_nb = cell_value[g-1];
         end
         if (g == DEPTH-1) begin : g_last
            assign right_nb = cell_value[g];
         end else begin : g_inner_r
            assign right_nb = cell_value[g+1];
         end

         sle_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl[g]),
            .count       (count_ff),
            .left_value  (left_nb),
            .right_value (right_nb),
            .cell_value  (cell_value[g]),
            .lt_flag     (lt_vec[g]),
            .eq_flag     (eq_vec[g])
         );
      end
   endgenerate

   // per-cell action, from its own flag and the flag of its left neighbor
   // the list is sorted, so the less-than flags form a prefix and the first
   // cell without one is the insert point and, if the key is present, the first equal entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         logic lt_prev;
         lt_prev = (i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i-1];
         boundary[i] = !lt_vec[i] && lt_prev;
         ctrl[i].key = key_ff;
         ctrl[i].act = sle_pkg::ACT_HOLD;
         if (state_ff == ST_APPLY) begin
            if (is_insert && !table_full && !lt_vec[i]) begin
               ctrl[i].act = lt_prev ? sle_pkg::ACT_LOAD_KEY : sle_pkg::ACT_TAKE_LEFT;
            end else if (is_delete && key_found && !lt_vec[i]) begin
               ctrl[i].act = sle_pkg::ACT_TAKE_RIGHT;
            end
         end
      end
   end

   // boundary has at most one bit set; index kept to the width of the position field
   always_comb begin
      boundary_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (boundary[i]) begin
            boundary_pos = boundary_pos | sle_pkg::POS_W'(i);
         end
      end
   end

   // sequencer and response
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      count_in        = count_ff;
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               key_in   = req_value;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            rsp_strobe_in   = 1'b1;
            rsp_status_in   = sle_pkg::STATUS_NOT_FOUND;
            rsp_position_in = '0;
            if (is_insert) begin
               if (table_full) begin
                  rsp_status_in = sle_pkg::STATUS_FULL;
               end else begin
                  rsp_status_in   = sle_pkg::STATUS_DONE;
                  rsp_position_in = boundary_pos;
                  count_in        = count_ff + CNT_W'(1);
               end
            end else if ((is_delete || is_search) && key_found) begin
               rsp_status_in   = sle_pkg::STATUS_DONE;
               rsp_position_in = boundary_pos;
               if (is_delete) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            rsp_count_in = sle_pkg::COUNT_W'(count_in);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      key_ff          <= key_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_count = rsp_count_ff;

   // a response only follows an apply cycle
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_APPLY))
      else $error("response strobe without apply cycle");

   // fill count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   // a refused insert leaves the fill count alone
   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && is_insert && table_full) |=> $stable(count_ff))
      else $error("refused insert changed the fill count");

   // sorted order: the less-than flags form a prefix of the chain
   a_lt_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> ((lt_vec & ~(lt_vec << 1) & ~DEPTH'(1)) == '0))
      else $error("cell order broken");

endmodule

`default_nettype wire

// File: bench/sorted_list_engine_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// self-checking bench for the sorted list engine: a shadow list predicts
// status, position and count for every accepted command, and each response
// strobe is checked against the oldest prediction
// ----------------------------------------------------------------------------

module sorted_list_engine_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = sle_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;

   // op code 3 is not decoded by the block, it must leave everything alone
   localparam logic [sle_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic signed [sle_pkg::VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [sle_pkg::VALUE_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [sle_pkg::STATUS_W-1:0] status;
      logic [sle_pkg::POS_W-1:0]    position;
      logic [sle_pkg::COUNT_W-1:0]  entry_count;
   } list_outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [sle_pkg::OP_W-1:0] req_op;
   logic signed [sle_pkg::VALUE_W-1:0] req_value;
   logic rsp_strobe;
   logic [sle_pkg::STATUS_W-1:0] rsp_status;
   logic [sle_pkg::POS_W-1:0] rsp_position;
   logic [sle_pkg::COUNT_W-1:0] rsp_entry_count;

   // shadow copy of the list, only slots below shadow_count are ever read
   logic signed [sle_pkg::VALUE_W-1:0] shadow_list [DEPTH];
   int shadow_count = 0;

   list_outcome_type outcome_queue [$];

   int idle_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int checked_count = 0;
   int full_count = 0;
   int miss_count = 0;
   int op_count [4] = '{0, 0, 0, 0};

   sorted_list_engine #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_position(rsp_position),
      .rsp_entry_count(rsp_entry_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // applies one command to the shadow list and returns the response it implies
   function automatic list_outcome_type apply_to_shadow_list(
      logic [sle_pkg::OP_W-1:0] op, logic signed [sle_pkg::VALUE_W-1:0] key);
      list_outcome_type o;
      int at;
      int i;
      o.status = sle_pkg::STATUS_NOT_FOUND;
      o.position = '0;
      case (op)
         sle_pkg::OP_INSERT: begin
            if (shadow_count >= DEPTH) begin
               o.status = sle_pkg::STATUS_FULL;
            end else begin
               // new key goes in front of every equal or larger entry
               at = 0;
               while (at < shadow_count && shadow_list[at] < key) at++;
               for (i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[at] = key;
               shadow_count++;
               o.status = sle_pkg::STATUS_DONE;
               o.position = sle_pkg::POS_W'(at);
            end
         end
         sle_pkg::OP_DELETE, sle_pkg::OP_SEARCH: begin
            // first equal entry, the last valid slot included
            at = 0;
            while (at < shadow_count && shadow_list[at] != key) at++;
            if (at < shadow_count) begin
               if (op == sle_pkg::OP_DELETE) begin
                  for (i = at; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
                  shadow_count--;
               end
               o.status = sle_pkg::STATUS_DONE;
               o.position = sle_pkg::POS_W'(at);
            end
         end
         default: begin
            // unused code: status not found, nothing moves
         end
      endcase
      o.entry_count = sle_pkg::COUNT_W'(shadow_count);
      return o;
   endfunction

   // transfer monitor: check responses first, then predict newly accepted commands
   // (a response never belongs to the command accepted at the same edge)
   always @(posedge clock) begin
      list_outcome_type exp_o;
      if (!reset) begin
         if (rsp_strobe) begin
            if (outcome_queue.size() == 0) begin
               $error("response transfer with no command outstanding");
               error_count++;
            end else begin
               exp_o = outcome_queue.pop_front();
               checked_count++;
               if (rsp_status !== exp_o.status) begin
                  $error("rsp_status: expected %0d, got %0d", exp_o.status, rsp_status);
                  error_count++;
               end
               if (rsp_position !== exp_o.position) begin
                  $error("rsp_position: expected %0d, got %0d",
                         exp_o.position, rsp_position);
                  error_count++;
               end
               if (rsp_entry_count !== exp_o.entry_count) begin
                  $error("rsp_entry_count: expected %0d, got %0d",
                         exp_o.entry_count, rsp_entry_count);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            exp_o = apply_to_shadow_list(req_op, req_value);
            outcome_queue.push_back(exp_o);
            op_count[req_op]++;
            if (exp_o.status == sle_pkg::STATUS_FULL) full_count++;
            if (exp_o.status == sle_pkg::STATUS_NOT_FOUND) miss_count++;
         end
      end
   end

   // one command transfer; random idle cycles in front, garbage on the bus meanwhile
   task automatic send_command(logic [sle_pkg::OP_W-1:0] op,
                               logic signed [sle_pkg::VALUE_W-1:0] key);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_op <= sle_pkg::OP_W'($urandom);
         req_value <= $urandom;
         @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_value <= key;
      // hold the command until an edge sees busy low
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending until every outstanding response has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (outcome_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // key picker: a stored key when asked for one and the list is not empty, otherwise extremes, a small
   // pool that breeds duplicates, or anything at all
   function automatic logic signed [sle_pkg::VALUE_W-1:0] pick_key(bit from_list);
      if (from_list && shadow_count > 0) return shadow_list[$urandom_range(shadow_count - 1)];
      case ($urandom_range(9))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2, 3, 4, 5: return $signed($urandom_range(8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // empty list: misses everywhere, unused code too
   task automatic test_empty_table();
      send_command(sle_pkg::OP_SEARCH, '0);
      send_command(sle_pkg::OP_DELETE, KEY_MIN);
      send_command(OP_UNUSED, KEY_MAX);
   endtask

   // extremes, duplicates, fill to the top, refused insert, head and tail hits
   task automatic test_fill_to_full();
      int k;
      send_command(sle_pkg::OP_INSERT, KEY_MAX);
      send_command(sle_pkg::OP_INSERT, KEY_MIN);
      send_command(sle_pkg::OP_INSERT, '0);
      send_command(sle_pkg::OP_INSERT, '0);
      send_command(sle_pkg::OP_INSERT, -1);
      send_command(sle_pkg::OP_INSERT, 1);
      for (k = 0; k < DEPTH - 6; k++) send_command(sle_pkg::OP_INSERT, $urandom);
      send_command(sle_pkg::OP_INSERT, 5);
      send_command(sle_pkg::OP_SEARCH, KEY_MAX);
      send_command(sle_pkg::OP_SEARCH, KEY_MIN);
      send_command(sle_pkg::OP_DELETE, '0);
      send_command(sle_pkg::OP_SEARCH, 32'sh1234_5678);
      send_command(OP_UNUSED, '0);
      send_command(sle_pkg::OP_DELETE, KEY_MAX);
      send_command(sle_pkg::OP_DELETE, KEY_MIN);
   endtask

   // random traffic in alternating grow and shrink stretches so the list
   // keeps running into full and into empty
   task automatic test_random_traffic(int n_items, int pct);
      int k;
      int r;
      bit grow;
      logic [sle_pkg::OP_W-1:0] op;
      grow = 1'b1;
      idle_pct = pct;
      for (k = 0; k < n_items; k++) begin
         if (k % 64 == 63) grow = ~grow;
         r = $urandom_range(99);
         if (r < 3) op = OP_UNUSED;
         else if (grow) op = (r < 60) ? sle_pkg::OP_INSERT :
                             (r < 80) ? sle_pkg::OP_DELETE : sle_pkg::OP_SEARCH;
         else op = (r < 25) ? sle_pkg::OP_INSERT :
                   (r < 70) ? sle_pkg::OP_DELETE : sle_pkg::OP_SEARCH;
         if (op == sle_pkg::OP_INSERT || op == OP_UNUSED) send_command(op, pick_key(1'b0));
         else send_command(op, pick_key($urandom_range(99) < 70));
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= sle_pkg::OP_INSERT;
      req_value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_fill_to_full();
      wait_for_drain();

      // sender idles rarely, then often, then never
      test_random_traffic(500, 7);
      wait_for_drain();
      test_random_traffic(500, 68);
      wait_for_drain();
      test_random_traffic(500, 0);
      wait_for_drain();

      $display("covered %0d inserts, %0d deletes, %0d searches, %0d unused-code commands",
               op_count[sle_pkg::OP_INSERT], op_count[sle_pkg::OP_DELETE],
               op_count[sle_pkg::OP_SEARCH], op_count[OP_UNUSED]);
      $display("%0d responses checked, %0d refused as full, %0d misses, %0d errors",
               checked_count, full_count, miss_count, error_count);
      if (error_count == 0 && outcome_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
